[hdl/dss_pkg.sv]
`default_nettype none
package dss_pkg;

	localparam int SCORE_W = 16;
	localparam int TAG_W   = 16;
	localparam int RANK_W  = 6;
	localparam int REC_W   = SCORE_W + TAG_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PUT,
		ST_EMIT_RD,
		ST_EMIT_OUT
	} state_t;

	typedef enum logic [1:0] {
		RD_TOP,
		RD_NEXT,
		RD_EMIT
	} rd_sel_t;

	typedef struct packed {
		logic    capture;
		logic    set_dropped;
		logic    k_load;
		logic    k_dec;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    wr_new;
		logic    wr_shift;
		logic    inc_count;
		logic    e_inc;
		logic    end_set;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic k_is_one;
		logic rd_ge;
		logic last_in;
		logic e_last;
	} status_t;

endpackage
`default_nettype wire

[hdl/dss_ctrl.sv]
`default_nettype none
module dss_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	output logic                  out_valid,
	input  wire logic             out_stall,
	input  wire logic             last_entry,
	input  wire dss_pkg::status_t sts,
	output dss_pkg::cmd_t         cmd
);

	dss_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dss_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		cmd.rd_sel = dss_pkg::RD_TOP;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			dss_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					if (sts.full) begin
						cmd.set_dropped = 1'b1;
						state_d = last_entry ? dss_pkg::ST_EMIT_RD : dss_pkg::ST_IDLE;
					end else if (sts.empty) begin
						cmd.k_load = 1'b1;
						state_d = dss_pkg::ST_PUT;
					end else begin
						cmd.k_load = 1'b1;
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = dss_pkg::RD_TOP;
						state_d = dss_pkg::ST_SCAN;
					end
				end
			end
			dss_pkg::ST_SCAN: begin
				if (sts.rd_ge) begin
					cmd.wr_new    = 1'b1;
					cmd.inc_count = 1'b1;
					state_d = sts.last_in ? dss_pkg::ST_EMIT_RD : dss_pkg::ST_IDLE;
				end else begin
					cmd.wr_shift = 1'b1;
					cmd.k_dec    = 1'b1;
					if (sts.k_is_one) begin
						state_d = dss_pkg::ST_PUT;
					end else begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = dss_pkg::RD_NEXT;
					end
				end
			end
			dss_pkg::ST_PUT: begin
				cmd.wr_new    = 1'b1;
				cmd.inc_count = 1'b1;
				state_d = sts.last_in ? dss_pkg::ST_EMIT_RD : dss_pkg::ST_IDLE;
			end
			dss_pkg::ST_EMIT_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = dss_pkg::RD_EMIT;
				state_d = dss_pkg::ST_EMIT_OUT;
			end
			dss_pkg::ST_EMIT_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					if (sts.e_last) begin
						cmd.end_set = 1'b1;
						state_d = dss_pkg::ST_IDLE;
					end else begin
						cmd.e_inc = 1'b1;
						state_d = dss_pkg::ST_EMIT_RD;
					end
				end
			end
			default: begin
				state_d = dss_pkg::ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

[hdl/dss_datapath.sv]
`default_nettype none
module dss_datapath #(
	parameter int MAX_ENTRIES = 32
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire dss_pkg::cmd_t               cmd,
	output dss_pkg::status_t                 sts,
	input  wire logic [dss_pkg::SCORE_W-1:0] entry_score,
	input  wire logic [dss_pkg::TAG_W-1:0]   entry_tag,
	input  wire logic                        last_entry,
	output logic [dss_pkg::SCORE_W-1:0]      sorted_score,
	output logic [dss_pkg::TAG_W-1:0]        sorted_tag,
	output logic [dss_pkg::RANK_W-1:0]       rank,
	output logic                             overflow,
	output logic                             last_result
);

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);

	logic [dss_pkg::REC_W-1:0]   store_q [MAX_ENTRIES];
	logic [dss_pkg::REC_W-1:0]   rd_q;
	logic [dss_pkg::SCORE_W-1:0] new_score_q;
	logic [dss_pkg::TAG_W-1:0]   new_tag_q;
	logic                        last_q;
	logic [CW-1:0]               count_q;
	logic                        dropped_q;
	logic [AW-1:0]               k_q;
	logic [AW-1:0]               e_q;
	logic [AW-1:0]               rd_addr;
	logic [dss_pkg::REC_W-1:0]   wr_data;

	always_comb begin
		case (cmd.rd_sel)
			dss_pkg::RD_TOP:  rd_addr = AW'(count_q - CW'(1));
			dss_pkg::RD_NEXT: rd_addr = k_q - AW'(2);
			dss_pkg::RD_EMIT: rd_addr = e_q;
			default:          rd_addr = e_q;
		endcase
	end

	assign wr_data = cmd.wr_new ? {new_score_q, new_tag_q} : rd_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_new || cmd.wr_shift) begin
			store_q[k_q] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_q <= store_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			new_score_q <= entry_score;
			new_tag_q   <= entry_tag;
			last_q      <= last_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			dropped_q <= 1'b0;
			k_q       <= '0;
			e_q       <= '0;
		end else begin
			if (cmd.end_set) begin
				count_q   <= '0;
				dropped_q <= 1'b0;
				e_q       <= '0;
			end else begin
				if (cmd.inc_count) begin
					count_q <= count_q + CW'(1);
				end
				if (cmd.set_dropped) begin
					dropped_q <= 1'b1;
				end
				if (cmd.e_inc) begin
					e_q <= e_q + AW'(1);
				end
			end
			if (cmd.k_load) begin
				k_q <= AW'(count_q);
			end else if (cmd.k_dec) begin
				k_q <= k_q - AW'(1);
			end
		end
	end

	assign sts.full     = (count_q == CW'(MAX_ENTRIES));
	assign sts.empty    = (count_q == '0);
	assign sts.k_is_one = (k_q == AW'(1));
	assign sts.rd_ge    = (rd_q[dss_pkg::REC_W-1 -: dss_pkg::SCORE_W] >= new_score_q);
	assign sts.last_in  = last_q;
	assign sts.e_last   = ((CW'(e_q) + CW'(1)) == count_q);

	assign sorted_score = rd_q[dss_pkg::REC_W-1 -: dss_pkg::SCORE_W];
	assign sorted_tag   = rd_q[dss_pkg::TAG_W-1:0];
	assign rank         = dss_pkg::RANK_W'(e_q);
	assign overflow     = dropped_q;
	assign last_result  = sts.e_last;

endmodule
`default_nettype wire

[hdl/descending_score_sorter.sv]
// Collects score/tag records and, on the record marked last, emits all stored records
// in descending score order with their rank; equal scores come out in arrival order.
// Records past MAX_ENTRIES are dropped and overflow is set on every result of that set.
// A record is inserted by walking the stored entries from the lowest score upward,
// shifting each lower-scored entry up one address until its place is found; the walk
// reads one entry and writes one entry of the record memory each cycle. A dropped
// record is accepted without a walk. Each result is one memory read followed by one
// transfer, and input is stalled while a record is being inserted or a set emitted.
`default_nettype none
module descending_score_sorter #(
	parameter int MAX_ENTRIES = 32
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [dss_pkg::SCORE_W-1:0] entry_score,
	input  wire logic [dss_pkg::TAG_W-1:0]   entry_tag,
	input  wire logic                        last_entry,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [dss_pkg::SCORE_W-1:0]      sorted_score,
	output logic [dss_pkg::TAG_W-1:0]        sorted_tag,
	output logic [dss_pkg::RANK_W-1:0]       rank,
	output logic                             overflow,
	output logic                             last_result
);

	dss_pkg::cmd_t    cmd;
	dss_pkg::status_t sts;

	dss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.last_entry(last_entry),
		.sts       (sts),
		.cmd       (cmd)
	);

	dss_datapath #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.entry_score (entry_score),
		.entry_tag   (entry_tag),
		.last_entry  (last_entry),
		.sorted_score(sorted_score),
		.sorted_tag  (sorted_tag),
		.rank        (rank),
		.overflow    (overflow),
		.last_result (last_result)
	);

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> !out_valid)
		else $error("input transfer during result output");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last_result) |=> (!in_stall && !out_valid))
		else $error("block not idle after final result");

	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.wr_new, cmd.wr_shift, cmd.rd_sel == dss_pkg::RD_EMIT && cmd.rd_en}))
		else $error("conflicting memory commands");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last_result) |=> !out_valid)
		else $error("result shown without a fresh read");
`endif

endmodule
`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 1ps
module testbench;
	localparam int SCORE_W = dss_pkg::SCORE_W;
	localparam int TAG_W   = dss_pkg::TAG_W;
	localparam int RANK_W  = dss_pkg::RANK_W;

	localparam int MAX_ENTRIES  = 32;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int SETTLE_TICKS = 2 * MAX_ENTRIES + 8;

	typedef enum int {
		KEY_FULL,
		KEY_NARROW,
		KEY_EDGE,
		KEY_MIXED
	} key_spread_t;

	typedef struct packed {
		logic [SCORE_W-1:0] score;
		logic [TAG_W-1:0]   tag;
		logic [RANK_W-1:0]  pos;
		logic               ovf;
		logic               tail;
	} ranked_rec_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [SCORE_W-1:0] entry_score;
	logic [TAG_W-1:0]   entry_tag;
	logic               last_entry;
	logic               out_valid;
	logic               out_stall;
	logic [SCORE_W-1:0] sorted_score;
	logic [TAG_W-1:0]   sorted_tag;
	logic [RANK_W-1:0]  rank;
	logic               overflow;
	logic               last_result;

	logic [SCORE_W-1:0] board_scores [MAX_ENTRIES];
	logic [TAG_W-1:0]   board_tags [MAX_ENTRIES];
	int                 board_count = 0;
	bit                 board_dropped = 1'b0;
	ranked_rec_t        pending_ranks [$];

	bit idle_on = 1'b1;
	int hold_len = 0;
	int rx_gap = 0;
	int error_count = 0;
	int cycle_count = 0;

	descending_score_sorter #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.entry_score(entry_score),
		.entry_tag(entry_tag),
		.last_entry(last_entry),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sorted_score(sorted_score),
		.sorted_tag(sorted_tag),
		.rank(rank),
		.overflow(overflow),
		.last_result(last_result)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic bit note_error();
		error_count++;
		return error_count <= 10;
	endfunction

	function automatic void place_record(input logic [SCORE_W-1:0] s,
			input logic [TAG_W-1:0] t, input logic is_last);
		int pos;
		int k;
		ranked_rec_t r;
		if (board_count >= MAX_ENTRIES) begin
			board_dropped = 1'b1;
		end else begin
			pos = 0;
			while (pos < board_count && board_scores[pos] >= s)
				pos++;
			for (k = board_count; k > pos; k--) begin
				board_scores[k] = board_scores[k-1];
				board_tags[k]   = board_tags[k-1];
			end
			board_scores[pos] = s;
			board_tags[pos]   = t;
			board_count++;
		end
		if (is_last) begin
			for (k = 0; k < board_count; k++) begin
				r.score = board_scores[k];
				r.tag   = board_tags[k];
				r.pos   = RANK_W'(k);
				r.ovf   = board_dropped;
				r.tail  = (k == board_count - 1);
				pending_ranks.push_back(r);
			end
			board_count   = 0;
			board_dropped = 1'b0;
		end
	endfunction

	// check each result transfer, then pick the next stall value
	always @(posedge clk) begin : result_check
		ranked_rec_t got;
		ranked_rec_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = {sorted_score, sorted_tag, rank, overflow, last_result};
			if (pending_ranks.size() == 0) begin
				if (note_error())
					$display("unexpected result: score %h tag %h rank %0d ovf %b last %b",
						got.score, got.tag, got.pos, got.ovf, got.tail);
			end else begin
				want = pending_ranks.pop_front();
				if (got.score !== want.score || got.tag !== want.tag ||
						got.pos !== want.pos || got.ovf !== want.ovf ||
						got.tail !== want.tail) begin
					if (note_error())
						$display({"mismatch: expected score %h tag %h rank %0d ovf %b last %b,",
							" got score %h tag %h rank %0d ovf %b last %b"},
							want.score, want.tag, want.pos, want.ovf, want.tail,
							got.score, got.tag, got.pos, got.ovf, got.tail);
				end
			end
		end
		if (hold_len > 0) begin
			out_stall <= 1'b1;
			hold_len <= hold_len - 1;
		end else if (rx_gap > 0) begin
			out_stall <= 1'b1;
			rx_gap--;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			out_stall <= 1'b1;
			rx_gap = $urandom_range(1, 15) - 1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic offer_record(input logic [SCORE_W-1:0] s, input logic [TAG_W-1:0] t,
			input logic is_last);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		entry_score <= s;
		entry_tag   <= t;
		last_entry  <= is_last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		place_record(s, t, is_last);
	endtask

	// drop valid and hold until every expected result has come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_ranks.size() != 0) @(posedge clk);
	endtask

	task automatic send_set(input int n, input key_spread_t spread);
		int i;
		key_spread_t pick;
		logic [SCORE_W-1:0] s;
		for (i = 0; i < n; i++) begin
			pick = spread;
			if (spread == KEY_MIXED)
				pick = key_spread_t'($urandom_range(0, 2));
			case (pick)
				KEY_NARROW: s = SCORE_W'($urandom_range(0, 3));
				KEY_EDGE:   s = $urandom_range(0, 1) ? '1 : '0;
				default:    s = SCORE_W'($urandom);
			endcase
			offer_record(s, TAG_W'($urandom), i == n - 1);
		end
	endtask

	task automatic test_lone_record();
		offer_record(16'h0000, 16'hFFFF, 1'b1);
		offer_record(16'hFFFF, 16'h0000, 1'b1);
		wait_drained();
	endtask

	task automatic test_key_extremes();
		offer_record(16'h5555, 16'h0001, 1'b0);
		offer_record(16'hFFFF, 16'h0002, 1'b0);
		offer_record(16'h0000, 16'h0003, 1'b0);
		offer_record(16'h5555, 16'h0004, 1'b0);
		offer_record(16'hAAAA, 16'h0005, 1'b0);
		offer_record(16'hFFFF, 16'h0006, 1'b0);
		offer_record(16'h0000, 16'h0007, 1'b1);
		wait_drained();
	endtask

	task automatic test_sort_order();
		int i;
		for (i = 1; i <= 5; i++)
			offer_record(SCORE_W'(i), TAG_W'(16'hA5A0 + i), i == 5);
		for (i = 5; i >= 1; i--)
			offer_record(SCORE_W'(i), TAG_W'(16'h5A50 + i), i == 1);
		wait_drained();
	endtask

	task automatic test_store_full();
		send_set(MAX_ENTRIES, KEY_MIXED);
		send_set(MAX_ENTRIES + 1, KEY_FULL);
		send_set(MAX_ENTRIES + 5, KEY_NARROW);
		wait_drained();
	endtask

	task automatic test_random_sets();
		int sent;
		int n;
		sent = 0;
		while (sent < 110) begin
			if ($urandom_range(0, 9) == 0)
				n = $urandom_range(9, MAX_ENTRIES + 8);
			else
				n = $urandom_range(1, 8);
			send_set(n, key_spread_t'($urandom_range(0, 3)));
			sent += n;
		end
		wait_drained();
	endtask

	// hold the output off while input keeps coming, so the block backs up
	task automatic test_output_backpressure();
		hold_len = 300;
		send_set(12, KEY_MIXED);
		send_set(6, KEY_NARROW);
		wait_drained();
	endtask

	task automatic test_drain_pause();
		send_set(8, KEY_FULL);
		wait_drained();
		send_set(7, KEY_MIXED);
		wait_drained();
	endtask

	task automatic test_full_rate();
		int sent;
		int n;
		idle_on = 1'b0;
		sent = 0;
		while (sent < 60) begin
			n = $urandom_range(1, 10);
			send_set(n, key_spread_t'($urandom_range(0, 3)));
			sent += n;
		end
		wait_drained();
	endtask

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		entry_score = '0;
		entry_tag   = '0;
		last_entry  = 1'b0;
		out_stall   = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_lone_record();
		test_key_extremes();
		test_sort_order();
		test_store_full();
		test_random_sets();
		test_output_backpressure();
		test_drain_pause();
		test_full_rate();

		repeat (SETTLE_TICKS) @(posedge clk);
		if (error_count == 0 && pending_ranks.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
